// ===== rtl/cyclic_permutation_pointer_chase_top_defines.svh =====
// Assertion macros used by the checker file of the pointer-chase block.
`ifndef CYCLIC_PERMUTATION_POINTER_CHASE_TOP_DEFINES_SVH
`define CYCLIC_PERMUTATION_POINTER_CHASE_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CPPC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cppc: same-cycle port check failed");

// Consequent must hold in the cycle after the antecedent.
`define CPPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cppc: next-cycle port check failed");

`endif

// ===== rtl/cppc_pkg.sv =====
// Types, constants and command/status structs of the pointer-chase block.
`timescale 1ns / 1ps
package cppc_pkg;

  localparam int unsigned DEPTH     = 65536;
  localparam int unsigned POS_W     = 16;
  localparam int unsigned SIZE_W    = 17;
  localparam int unsigned STEP_W    = 32;
  localparam int unsigned SEED_W    = 32;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned LCG_W     = 48;
  localparam int unsigned CHUNK_W   = 16;
  localparam int unsigned MUL_W     = 35;
  localparam int unsigned PROD_W    = CHUNK_W + MUL_W;
  localparam int unsigned DRAW_W    = 31;
  localparam int unsigned DRAW_LSB  = LCG_W - DRAW_W;
  localparam int unsigned DIV_CNT_W = $clog2(DRAW_W);

  localparam logic [MUL_W-1:0]   LCG_MUL  = 35'h5DEECE66D;
  localparam logic [LCG_W-1:0]   LCG_ADD  = 48'hB;
  localparam logic [CHUNK_W-1:0] SEED_LOW = 16'h330E;

  localparam logic [SIZE_W-1:0] DEPTH_SIZE  = SIZE_W'(DEPTH);
  localparam logic [SIZE_W-1:0] RESET_SIZE  = SIZE_W'(65536);
  localparam logic [STEP_W-1:0] RESET_STEPS = STEP_W'(100000000);
  localparam logic [SEED_W-1:0] RESET_SEED  = SEED_W'(123);

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEPS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED  = 2'd2;

  localparam logic CMD_GENERATE = 1'b0;
  localparam logic CMD_FOLLOW   = 1'b1;

  typedef enum logic [1:0] {
    SCR_RD_IDX,
    SCR_RD_J,
    SCR_RD_ZERO
  } scr_rd_e;

  typedef enum logic [1:0] {
    SCR_WR_NONE,
    SCR_WR_INIT,
    SCR_WR_I,
    SCR_WR_J
  } scr_wr_e;

  typedef enum logic [1:0] {
    SUCC_WR_NONE,
    SUCC_WR_LINK,
    SUCC_WR_CLOSE
  } succ_wr_e;

  typedef enum logic [1:0] {
    RES_GEN,
    RES_OOR,
    RES_POS,
    RES_WALK
  } res_e;

  typedef struct packed {
    logic     accept;
    logic     lcg_seed;
    logic     lcg_start;
    logic     mod_start;
    logic     idx_clr;
    logic     idx_one;
    logic     idx_inc;
    logic     idx_dec;
    scr_rd_e  scr_rd;
    scr_wr_e  scr_wr;
    logic     tmp_load;
    logic     link_first;
    succ_wr_e succ_wr;
    logic     walk_start;
    logic     walk_step;
    logic     res_load;
    res_e     res_sel;
    logic     out_load;
  } cppc_cmd_t;

  typedef struct packed {
    logic cmd_follow;
    logic oor;
    logic steps_zero;
    logic last_step;
    logic idx_zero;
    logic idx_last;
    logic lcg_done;
    logic mod_done;
  } cppc_status_t;

endpackage

// ===== rtl/cppc_if.sv =====
// Valid/ready channel interfaces for command input and result output.
`timescale 1ns / 1ps
interface cppc_in_if import cppc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [POS_W-1:0] start_position;

  modport source (output valid, cmd, start_position, input ready);
  modport sink   (input valid, cmd, start_position, output ready);
endinterface

interface cppc_out_if import cppc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] end_position;
  logic             out_of_range;
  logic             done_res;

  modport source (output valid, end_position, out_of_range, done_res, input ready);
  modport sink   (input valid, end_position, out_of_range, done_res, output ready);
endinterface

// ===== rtl/cppc_lcg.sv =====
// 48-bit linear congruential generator, multiply done in three 16-bit partial products.
`timescale 1ns / 1ps
module cppc_lcg import cppc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              seed_load_i,
  input  logic [SEED_W-1:0] seed_i,
  input  logic              start_i,
  output logic [DRAW_W-1:0] draw_o,
  output logic              done_o
);

  logic [LCG_W-1:0]   x_q, x_d;
  logic [LCG_W-1:0]   acc_q, acc_d;
  logic [1:0]         phase_q, phase_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CHUNK_W-1:0] chunk;
  logic [PROD_W-1:0]  prod;
  logic [LCG_W-1:0]   pp;
  logic [LCG_W-1:0]   acc_sum;

  always_comb begin
    unique case (phase_q)
      2'd0:    chunk = x_q[CHUNK_W-1:0];
      2'd1:    chunk = x_q[2*CHUNK_W-1:CHUNK_W];
      default: chunk = x_q[3*CHUNK_W-1:2*CHUNK_W];
    endcase
  end

  assign prod = {{MUL_W{1'b0}}, chunk} * {{CHUNK_W{1'b0}}, LCG_MUL};

  // keep only the bits that land below 2^48 after the chunk shift
  always_comb begin
    unique case (phase_q)
      2'd0:    pp = prod[LCG_W-1:0];
      2'd1:    pp = {prod[LCG_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
      default: pp = {prod[LCG_W-2*CHUNK_W-1:0], {(2*CHUNK_W){1'b0}}};
    endcase
  end

  assign acc_sum = acc_q + pp;

  always_comb begin
    x_d     = x_q;
    acc_d   = acc_q;
    phase_d = phase_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (seed_load_i) begin
      x_d = {seed_i, SEED_LOW};
    end else if (start_i) begin
      acc_d   = '0;
      phase_d = 2'd0;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      acc_d   = acc_sum;
      phase_d = phase_q + 2'd1;
      if (phase_q == 2'd2) begin
        x_d    = acc_sum + LCG_ADD;
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q     <= '0;
      phase_q <= 2'd0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      x_q     <= x_d;
      phase_q <= phase_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign draw_o = x_q[LCG_W-1:DRAW_LSB];
  assign done_o = done_q;

endmodule

// ===== rtl/cppc_divmod.sv =====
// Restoring remainder unit: one dividend bit per cycle.
`timescale 1ns / 1ps
module cppc_divmod import cppc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DRAW_W-1:0] dividend_i,
  input  logic [SIZE_W-1:0] divisor_i,
  output logic [POS_W-1:0]  rem_o,
  output logic              done_o
);

  logic [DRAW_W-1:0]    dvd_q, dvd_d;
  logic [SIZE_W-1:0]    div_q, div_d;
  logic [SIZE_W-1:0]    rem_q, rem_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [SIZE_W:0]      shifted;
  logic [SIZE_W:0]      diff;

  assign shifted = {rem_q, dvd_q[DRAW_W-1]};
  assign diff    = shifted - {1'b0, div_q};

  always_comb begin
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = DIV_CNT_W'(DRAW_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // subtract when the partial remainder reaches the divisor
      if (shifted >= {1'b0, div_q}) begin
        rem_d = diff[SIZE_W-1:0];
      end else begin
        rem_d = shifted[SIZE_W-1:0];
      end
      dvd_d = {dvd_q[DRAW_W-2:0], 1'b0};
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign rem_o  = rem_q[POS_W-1:0];
  assign done_o = done_q;

endmodule

// ===== rtl/cppc_dp.sv =====
// Datapath: configuration, scratch and successor memories, index and walk registers.
`timescale 1ns / 1ps
module cppc_dp import cppc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_cmd_i,
  input  logic [POS_W-1:0]     in_start_i,
  input  cppc_cmd_t            cmd_i,
  output cppc_status_t         status_o,
  output logic [POS_W-1:0]     out_end_o,
  output logic                 out_oor_o
);

  logic [SIZE_W-1:0] size_q;
  logic [STEP_W-1:0] steps_q;
  logic [SEED_W-1:0] seed_q;

  logic              cmd_q;
  logic [POS_W-1:0]  start_q;
  logic [POS_W-1:0]  idx_q, idx_d;
  logic [POS_W-1:0]  tmp_q;
  logic [POS_W-1:0]  first_q;
  logic [POS_W-1:0]  cur_q;
  logic [STEP_W-1:0] steps_left_q;
  logic [POS_W-1:0]  res_pos_q;
  logic              res_oor_q;
  logic [POS_W-1:0]  out_end_q;
  logic              out_oor_q;

  logic [SIZE_W-1:0] eff_n;
  logic [POS_W-1:0]  last_idx;
  logic [SIZE_W-1:0] divisor;
  logic [DRAW_W-1:0] draw;
  logic [POS_W-1:0]  j_pos;
  logic              lcg_done;
  logic              mod_done;

  logic [POS_W-1:0]  scr_mem [DEPTH];
  logic [POS_W-1:0]  scr_rdata_q;
  logic [POS_W-1:0]  scr_raddr;
  logic              scr_we;
  logic [POS_W-1:0]  scr_waddr;
  logic [POS_W-1:0]  scr_wdata;

  logic [POS_W-1:0]  succ_mem [DEPTH];
  logic [POS_W-1:0]  succ_rdata_q;
  logic              succ_re;
  logic [POS_W-1:0]  succ_raddr;
  logic              succ_we;
  logic [POS_W-1:0]  succ_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= RESET_SIZE;
      steps_q <= RESET_STEPS;
      seed_q  <= RESET_SEED;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SIZE:  size_q  <= cfg_data_i[SIZE_W-1:0];
        CFG_STEPS: steps_q <= cfg_data_i[STEP_W-1:0];
        CFG_SEED:  seed_q  <= cfg_data_i[SEED_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp size to 1..DEPTH
  always_comb begin
    if (size_q == '0) begin
      eff_n = SIZE_W'(1);
    end else if (size_q > DEPTH_SIZE) begin
      eff_n = DEPTH_SIZE;
    end else begin
      eff_n = size_q;
    end
  end

  assign last_idx = POS_W'(eff_n - SIZE_W'(1));
  assign divisor  = {1'b0, idx_q} + SIZE_W'(1);

  always_comb begin
    priority if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_one) begin
      idx_d = POS_W'(1);
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + POS_W'(1);
    end else if (cmd_i.idx_dec) begin
      idx_d = idx_q - POS_W'(1);
    end else begin
      idx_d = idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (cmd_i.accept) begin
      cmd_q   <= in_cmd_i;
      start_q <= in_start_i;
    end
    if (cmd_i.tmp_load) begin
      tmp_q <= scr_rdata_q;
    end
    if (cmd_i.link_first) begin
      first_q <= scr_rdata_q;
      cur_q   <= scr_rdata_q;
    end else if (cmd_i.succ_wr == SUCC_WR_LINK) begin
      cur_q <= scr_rdata_q;
    end
    if (cmd_i.walk_start) begin
      steps_left_q <= steps_q;
    end else if (cmd_i.walk_step) begin
      steps_left_q <= steps_left_q - STEP_W'(1);
    end
    if (cmd_i.res_load) begin
      unique case (cmd_i.res_sel)
        RES_GEN: begin
          res_pos_q <= '0;
          res_oor_q <= 1'b0;
        end
        RES_OOR: begin
          res_pos_q <= '0;
          res_oor_q <= 1'b1;
        end
        RES_POS: begin
          res_pos_q <= start_q;
          res_oor_q <= 1'b0;
        end
        RES_WALK: begin
          res_pos_q <= succ_rdata_q;
          res_oor_q <= 1'b0;
        end
      endcase
    end
    if (cmd_i.out_load) begin
      out_end_q <= res_pos_q;
      out_oor_q <= res_oor_q;
    end
  end

  cppc_lcg u_lcg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .seed_load_i(cmd_i.lcg_seed),
    .seed_i     (seed_q),
    .start_i    (cmd_i.lcg_start),
    .draw_o     (draw),
    .done_o     (lcg_done)
  );

  cppc_divmod u_divmod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.mod_start),
    .dividend_i(draw),
    .divisor_i (divisor),
    .rem_o     (j_pos),
    .done_o    (mod_done)
  );

  // scratch table
  always_comb begin
    case (cmd_i.scr_rd)
      SCR_RD_J:    scr_raddr = j_pos;
      SCR_RD_ZERO: scr_raddr = '0;
      default:     scr_raddr = idx_q;
    endcase
  end

  always_comb begin
    scr_we    = 1'b1;
    scr_waddr = idx_q;
    scr_wdata = idx_q;
    unique case (cmd_i.scr_wr)
      SCR_WR_NONE: scr_we = 1'b0;
      SCR_WR_INIT: scr_wdata = idx_q;
      SCR_WR_I:    scr_wdata = scr_rdata_q;
      SCR_WR_J: begin
        scr_waddr = j_pos;
        scr_wdata = tmp_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (scr_we) begin
      scr_mem[scr_waddr] <= scr_wdata;
    end
    scr_rdata_q <= scr_mem[scr_raddr];
  end

  // successor table; a walk feeds each read back as the next address
  assign succ_re    = cmd_i.walk_start | cmd_i.walk_step;
  assign succ_raddr = cmd_i.walk_start ? start_q : succ_rdata_q;
  assign succ_we    = (cmd_i.succ_wr == SUCC_WR_LINK) || (cmd_i.succ_wr == SUCC_WR_CLOSE);
  assign succ_wdata = (cmd_i.succ_wr == SUCC_WR_CLOSE) ? first_q : scr_rdata_q;

  always_ff @(posedge clk_i) begin
    if (succ_we) begin
      succ_mem[cur_q] <= succ_wdata;
    end
    if (succ_re) begin
      succ_rdata_q <= succ_mem[succ_raddr];
    end
  end

  assign status_o.cmd_follow = (cmd_q == CMD_FOLLOW);
  assign status_o.oor        = ({1'b0, start_q} >= eff_n);
  assign status_o.steps_zero = (steps_q == '0);
  assign status_o.last_step  = (steps_left_q == STEP_W'(1));
  assign status_o.idx_zero   = (idx_q == '0);
  assign status_o.idx_last   = (idx_q == last_idx);
  assign status_o.lcg_done   = lcg_done;
  assign status_o.mod_done   = mod_done;

  assign out_end_o = out_end_q;
  assign out_oor_o = out_oor_q;

endmodule

// ===== rtl/cppc_ctrl.sv =====
// Controller: sequences generate (fill, shuffle, link) and follow (walk) commands.
`timescale 1ns / 1ps
module cppc_ctrl import cppc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  cppc_status_t status_i,
  output cppc_cmd_t    cmd_o
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_START    = 5'd1;
  localparam logic [4:0] S_INIT     = 5'd2;
  localparam logic [4:0] S_SH_TOP   = 5'd3;
  localparam logic [4:0] S_SH_LCG   = 5'd4;
  localparam logic [4:0] S_SH_MOD   = 5'd5;
  localparam logic [4:0] S_SH_RDI   = 5'd6;
  localparam logic [4:0] S_SH_RDJ   = 5'd7;
  localparam logic [4:0] S_SH_WRI   = 5'd8;
  localparam logic [4:0] S_SH_WRJ   = 5'd9;
  localparam logic [4:0] S_LK_RD0   = 5'd10;
  localparam logic [4:0] S_LK_FIRST = 5'd11;
  localparam logic [4:0] S_LK_RD    = 5'd12;
  localparam logic [4:0] S_LK_WR    = 5'd13;
  localparam logic [4:0] S_LK_END   = 5'd14;
  localparam logic [4:0] S_FW_WALK  = 5'd15;
  localparam logic [4:0] S_DONE     = 5'd16;

  logic [4:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.scr_rd  = SCR_RD_IDX;
    cmd_o.scr_wr  = SCR_WR_NONE;
    cmd_o.succ_wr = SUCC_WR_NONE;
    cmd_o.res_sel = RES_GEN;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_START;
        end
      end
      S_START: begin
        priority if (!status_i.cmd_follow) begin
          cmd_o.lcg_seed = 1'b1;
          cmd_o.idx_clr  = 1'b1;
          state_d        = S_INIT;
        end else if (status_i.oor) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_OOR;
          state_d        = S_DONE;
        end else if (status_i.steps_zero) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_POS;
          state_d        = S_DONE;
        end else begin
          cmd_o.walk_start = 1'b1;
          state_d          = S_FW_WALK;
        end
      end
      S_INIT: begin
        cmd_o.scr_wr = SCR_WR_INIT;
        if (status_i.idx_last) begin
          state_d = S_SH_TOP;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_SH_TOP: begin
        if (status_i.idx_zero) begin
          state_d = S_LK_RD0;
        end else begin
          cmd_o.lcg_start = 1'b1;
          state_d         = S_SH_LCG;
        end
      end
      S_SH_LCG: begin
        if (status_i.lcg_done) begin
          cmd_o.mod_start = 1'b1;
          state_d         = S_SH_MOD;
        end
      end
      S_SH_MOD: begin
        if (status_i.mod_done) begin
          state_d = S_SH_RDI;
        end
      end
      S_SH_RDI: begin
        cmd_o.scr_rd = SCR_RD_IDX;
        state_d      = S_SH_RDJ;
      end
      S_SH_RDJ: begin
        cmd_o.tmp_load = 1'b1;
        cmd_o.scr_rd   = SCR_RD_J;
        state_d        = S_SH_WRI;
      end
      S_SH_WRI: begin
        cmd_o.scr_wr = SCR_WR_I;
        state_d      = S_SH_WRJ;
      end
      S_SH_WRJ: begin
        // j written last; a self-swap leaves the entry unchanged
        cmd_o.scr_wr  = SCR_WR_J;
        cmd_o.idx_dec = 1'b1;
        state_d       = S_SH_TOP;
      end
      S_LK_RD0: begin
        cmd_o.scr_rd = SCR_RD_ZERO;
        state_d      = S_LK_FIRST;
      end
      S_LK_FIRST: begin
        cmd_o.link_first = 1'b1;
        if (status_i.idx_last) begin
          state_d = S_LK_END;
        end else begin
          cmd_o.idx_one = 1'b1;
          state_d       = S_LK_RD;
        end
      end
      S_LK_RD: begin
        cmd_o.scr_rd = SCR_RD_IDX;
        state_d      = S_LK_WR;
      end
      S_LK_WR: begin
        cmd_o.succ_wr = SUCC_WR_LINK;
        if (status_i.idx_last) begin
          state_d = S_LK_END;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_LK_RD;
        end
      end
      S_LK_END: begin
        cmd_o.succ_wr  = SUCC_WR_CLOSE;
        cmd_o.res_load = 1'b1;
        cmd_o.res_sel  = RES_GEN;
        state_d        = S_DONE;
      end
      S_FW_WALK: begin
        if (status_i.last_step) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_WALK;
          state_d        = S_DONE;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/cyclic_permutation_pointer_chase_top.sv =====
// Follow: a start check loads the result directly when out of range or at zero steps, else a walk
// through the successor table ends in the result. Generate fills the scratch table, shuffles it
// with a generator multiply and a bit-serial remainder per swap, then links the successor table.
// One command at a time; the next transfer is taken while a result waits in the output register.
// Reset (async, active low) restores the config registers and clears control; the scratch and
// successor memories are not cleared and hold unknown data until a generate writes them.
`timescale 1ns / 1ps
module cyclic_permutation_pointer_chase_top import cppc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  cppc_in_if.sink              in_ch,
  cppc_out_if.source           out_ch,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  cppc_cmd_t    cmd;
  cppc_status_t status;

  cppc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .out_valid_o(out_ch.valid),
    .out_ready_i(out_ch.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cppc_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_cmd_i  (in_ch.cmd),
    .in_start_i(in_ch.start_position),
    .cmd_i     (cmd),
    .status_o  (status),
    .out_end_o (out_ch.end_position),
    .out_oor_o (out_ch.out_of_range)
  );

  assign out_ch.done_res = 1'b1;

endmodule

// ===== rtl/cppc_checker.sv =====
// Port-level checker for the pointer-chase block and its bind.
`timescale 1ns / 1ps
`include "cyclic_permutation_pointer_chase_top_defines.svh"
module cppc_checker import cppc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [POS_W-1:0] end_position_i,
  input logic             out_of_range_i,
  input logic             done_res_i
);

  `CPPC_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  `CPPC_ASSERT_SAME(a_done_set, out_valid_i, done_res_i)
  `CPPC_ASSERT_SAME(a_oor_zero, out_valid_i && out_of_range_i, end_position_i == '0)
  `CPPC_ASSERT_NEXT(a_busy_after_transfer, in_valid_i && in_ready_i, !in_ready_i)

endmodule

bind cyclic_permutation_pointer_chase_top cppc_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_ch.valid),
  .in_ready_i    (in_ch.ready),
  .out_valid_i   (out_ch.valid),
  .out_ready_i   (out_ch.ready),
  .end_position_i(out_ch.end_position),
  .out_of_range_i(out_ch.out_of_range),
  .done_res_i    (out_ch.done_res)
);
